// ===== hdl/dsa_pkg.sv =====
`default_nettype none

package dsa_pkg;

	localparam int SLOT_W    = 10;
	localparam int CAP_W     = 11;
	localparam int STRIDE_W  = 13;
	localparam int ADDR_W    = 48;
	localparam int OFF_W     = SLOT_W + STRIDE_W;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = ADDR_W;

	localparam logic MODE_ALLOC = 1'b0;
	localparam logic MODE_FREE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STRIDE      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HOST_BASE   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_DEVICE_BASE = 2'd3;

	localparam logic [CAP_W-1:0]    CAPACITY_RESET = 11'd1024;
	localparam logic [STRIDE_W-1:0] STRIDE_RESET   = 13'd32;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_EXHAUSTED  = 2'd1,
		ST_BAD_INDEX  = 2'd2,
		ST_STACK_FULL = 2'd3
	} status_t;

	typedef struct packed {
		logic              mode;
		logic [SLOT_W-1:0] slot_in;
	} req_t;

	typedef struct packed {
		status_t           status;
		logic [SLOT_W-1:0] slot_out;
		logic [ADDR_W-1:0] host_address;
		logic [ADDR_W-1:0] device_address;
	} resp_t;

	// Decision made at accept time, handed to the address datapath
	typedef struct packed {
		logic              valid;
		logic              granted;
		logic              from_stack;
		status_t           status;
		logic [SLOT_W-1:0] slot;
	} sel_t;

endpackage

`default_nettype wire

// ===== hdl/dsa_free_ram.sv =====
`default_nettype none

module dsa_free_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [AW-1:0]              waddr,
	input  wire logic [dsa_pkg::SLOT_W-1:0] wdata,
	input  wire logic                       re,
	input  wire logic [AW-1:0]              raddr,
	output logic      [dsa_pkg::SLOT_W-1:0] rdata
);
	import dsa_pkg::*;

	logic [SLOT_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/dsa_addr_gen.sv =====
`default_nettype none

module dsa_addr_gen (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         advance,
	input  wire dsa_pkg::sel_t                sel,
	input  wire logic [dsa_pkg::SLOT_W-1:0]   stack_rdata,
	input  wire logic [dsa_pkg::STRIDE_W-1:0] stride,
	input  wire logic [dsa_pkg::ADDR_W-1:0]   host_base,
	input  wire logic [dsa_pkg::ADDR_W-1:0]   device_base,
	output logic                              out_valid,
	output dsa_pkg::resp_t                    out_data
);
	import dsa_pkg::*;

	logic              valid_s2;
	logic              granted_s2;
	status_t           status_s2;
	logic [SLOT_W-1:0] slot_s2;
	logic [OFF_W-1:0]  off_s2;
	logic [SLOT_W-1:0] slot_pick;

	assign slot_pick = !sel.granted ? '0 : (sel.from_stack ? stack_rdata : sel.slot);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (advance) begin
			valid_s2  <= sel.valid;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			granted_s2 <= sel.granted;
			status_s2  <= sel.status;
			slot_s2    <= slot_pick;
			off_s2     <= OFF_W'(slot_pick) * OFF_W'(stride);
			out_data.status   <= status_s2;
			out_data.slot_out <= slot_s2;
			// zero addresses unless a slot was handed out
			out_data.host_address   <= granted_s2 ? host_base + ADDR_W'(off_s2) : '0;
			out_data.device_address <= granted_s2 ? device_base + ADDR_W'(off_s2) : '0;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/descriptor_slot_allocator.sv =====
`default_nettype none

// Channel   Dir  Handshake            Beat
// in        in   in_valid/in_stall    req_t  {mode, slot_in}
// out       out  out_valid/out_stall  resp_t {status, slot_out, host_address, device_address}
// cfg       in   cfg_we               cfg_index selects register, cfg_data carries value
//
// One request per cycle unless out stalls; results pass the sel_s1, s2 and output registers.
// Stack pointer and bump counter update at accept, and the free-stack RAM is
// written or read in that same cycle, so back-to-back push/pop needs no bypass.
// A stalled output freezes the whole pipeline and raises in_stall.
// Reset clears stack depth and bump counter; stack RAM contents are not cleared.

module descriptor_slot_allocator #(
	parameter int MAX_SLOTS  = 1024,
	parameter int FREE_DEPTH = 1024
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_stall,
	input  wire dsa_pkg::req_t                 in_data,
	output logic                               out_valid,
	input  wire logic                          out_stall,
	output dsa_pkg::resp_t                     out_data,
	input  wire logic                          cfg_we,
	input  wire logic [dsa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dsa_pkg::CFG_DAT_W-1:0] cfg_data
);
	import dsa_pkg::*;

	localparam int AW = (FREE_DEPTH > 1) ? $clog2(FREE_DEPTH) : 1;
	localparam int CW = $clog2(FREE_DEPTH + 1);
	localparam int BW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS + 1) : 1;

	logic [CAP_W-1:0]    cap_q;
	logic [STRIDE_W-1:0] stride_q;
	logic [ADDR_W-1:0]   host_base_q;
	logic [ADDR_W-1:0]   device_base_q;

	logic [CW-1:0] free_cnt_q;
	logic [BW-1:0] bump_q;
	sel_t          sel_s1;
	sel_t          sel_d;

	logic              advance;
	logic              accept;
	logic              do_pop;
	logic              do_push;
	logic              do_bump;
	logic [CW-1:0]     cnt_dec;
	logic [SLOT_W-1:0] stack_rdata;

	assign advance  = !out_valid || !out_stall;
	assign in_stall = !advance;
	assign accept   = in_valid && advance;
	assign cnt_dec  = free_cnt_q - 1'b1;

	always_comb begin
		do_pop         = 1'b0;
		do_push        = 1'b0;
		do_bump        = 1'b0;
		sel_d.valid    = accept;
		sel_d.granted  = 1'b0;
		sel_d.from_stack = 1'b0;
		sel_d.status   = ST_OK;
		sel_d.slot     = '0;
		if (in_data.mode == MODE_ALLOC) begin
			if (free_cnt_q != '0) begin
				do_pop           = 1'b1;
				sel_d.granted    = 1'b1;
				sel_d.from_stack = 1'b1;
			end else if ((32'(bump_q) < 32'(cap_q)) && (32'(bump_q) < MAX_SLOTS)) begin
				do_bump       = 1'b1;
				sel_d.granted = 1'b1;
				sel_d.slot    = SLOT_W'(bump_q);
			end else begin
				sel_d.status = ST_EXHAUSTED;
			end
		end else begin
			if ({1'b0, in_data.slot_in} >= cap_q) begin
				sel_d.status = ST_BAD_INDEX;
			end else if (32'(free_cnt_q) >= FREE_DEPTH) begin
				sel_d.status = ST_STACK_FULL;
			end else begin
				do_push = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q         <= CAPACITY_RESET;
			stride_q      <= STRIDE_RESET;
			host_base_q   <= '0;
			device_base_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CAPACITY:    cap_q         <= cfg_data[CAP_W-1:0];
				CFG_STRIDE:      stride_q      <= cfg_data[STRIDE_W-1:0];
				CFG_HOST_BASE:   host_base_q   <= cfg_data[ADDR_W-1:0];
				CFG_DEVICE_BASE: device_base_q <= cfg_data[ADDR_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_cnt_q <= '0;
			bump_q     <= '0;
			sel_s1     <= '0;
		end else if (advance) begin
			sel_s1 <= sel_d;
			if (accept && do_pop) begin
				free_cnt_q <= cnt_dec;
			end else if (accept && do_push) begin
				free_cnt_q <= free_cnt_q + 1'b1;
			end
			if (accept && do_bump) begin
				bump_q <= bump_q + 1'b1;
			end
		end
	end

	dsa_free_ram #(
		.DEPTH (FREE_DEPTH)
	) u_free_ram (
		.clk   (clk),
		.we    (accept && do_push),
		.waddr (free_cnt_q[AW-1:0]),
		.wdata (in_data.slot_in),
		.re    (accept && do_pop),
		.raddr (cnt_dec[AW-1:0]),
		.rdata (stack_rdata)
	);

	dsa_addr_gen u_addr_gen (
		.clk         (clk),
		.arst_n      (arst_n),
		.advance     (advance),
		.sel         (sel_s1),
		.stack_rdata (stack_rdata),
		.stride      (stride_q),
		.host_base   (host_base_q),
		.device_base (device_base_q),
		.out_valid   (out_valid),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire
